>>> hdl/guide_mismatch_hit_scan_top_macros.svh
// assertion macros for the hit scan block
`ifndef GUIDE_MISMATCH_HIT_SCAN_TOP_MACROS_SVH
`define GUIDE_MISMATCH_HIT_SCAN_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define GMHS_ASSERT(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define GMHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GMHS_ASSERT(lbl, clk, rst, expr, msg)
`define GMHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> hdl/gmhs_pkg.sv
`default_nettype none
package gmhs_pkg;

   localparam int SPACER_W = 40;
   localparam int BASES    = 20;
   localparam int MM_W     = 5;
   localparam int LIMIT_W  = 5;
   localparam int GBASE_W  = 8;
   localparam int WIN_W    = 16;
   localparam int RCNT_W   = 9;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_SCAN = 2'd1;
   localparam logic [1:0] OP_END  = 2'd2;

   localparam logic [1:0] BASE_G = 2'd2;

   localparam logic CSR_LIMIT = 1'b0;
   localparam logic CSR_BASE  = 1'b1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd3;
   localparam logic [GBASE_W-1:0] GBASE_RESET = 8'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_SUMMARY
   } state_type;

endpackage
`default_nettype wire

>>> hdl/gmhs_guide_ram.sv
`default_nettype none
module gmhs_guide_ram
   import gmhs_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [SPACER_W-1:0] wr_data,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output logic      [SPACER_W-1:0] rd_data
);

   logic [SPACER_W-1:0] mem [DEPTH];
   logic [SPACER_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/gmhs_base_cmp.sv
`default_nettype none
module gmhs_base_cmp
   import gmhs_pkg::*;
(
   input  wire logic [SPACER_W-1:0] guide,
   input  wire logic [SPACER_W-1:0] spacer,
   input  wire logic [LIMIT_W-1:0]  limit,
   output logic      [MM_W-1:0]     mismatches,
   output logic                     in_limit
);

   logic [SPACER_W-1:0] x;
   logic [BASES-1:0]    diff;

   always_comb begin
      x = guide ^ spacer;
      for (int i = 0; i < BASES; i++) begin
         diff[i] = |x[2*i +: 2];
      end
      mismatches = MM_W'($countones(diff));
      in_limit   = (mismatches <= limit);
   end

endmodule
`default_nettype wire

>>> hdl/guide_mismatch_hit_scan_top.sv
// guide mismatch hit scan
//
// input channel (req_*): one item per valid/ready transfer. opcode load writes
// a guide slot, opcode scan with G bases in req_pam[5:2] compares the spacer to
// every guide slot in order, opcode end of chunk returns one summary record.
// result channel (rsp_*): hit records and summaries, valid/ready.
// csr port: APB style, max_mismatch_limit at 0x0, guide_base at 0x4;
// pready is tied high, writes land on the access cycle.
// a scan is held up by receiver stalls; while it is not stalled, the guide
// memory gives one read per cycle, one slot compared per cycle.
// the final hit of a scan is held back until the scan ends so it can carry
// last; each new hit pushes the previous one into the output register.
// an end of chunk passes through a summary state. the next item is taken once
// the current one is finished, while its last record may still wait.
// when rsp_ready is low the scan stalls at a hit that finds both the held
// record and the output register full, and at its end until the held record
// moves out; an end of chunk waits for a free output register.
// reset clears the record counter, control state and valid flags and sets
// the csr registers to defaults; guide memory contents are undefined until loaded.
`default_nettype none
`include "guide_mismatch_hit_scan_top_macros.svh"
module guide_mismatch_hit_scan_top
   import gmhs_pkg::*;
#(
   parameter int GUIDE_SLOTS = 64,
   parameter int RECORD_CAP  = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [5:0]          req_guide_slot,
   input  wire logic [SPACER_W-1:0] req_spacer,
   input  wire logic [7:0]          req_pam,
   input  wire logic [WIN_W-1:0]    req_window_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_kind,
   output logic      [WIN_W-1:0]    rsp_hit_window,
   output logic      [GBASE_W-1:0]  rsp_guide_index,
   output logic      [MM_W-1:0]     rsp_mismatches,
   output logic      [RCNT_W-1:0]   rsp_record_count,
   output logic                     rsp_last,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic      [31:0]         prdata,
   output logic                     pready
);

   localparam int AW    = (GUIDE_SLOTS > 1) ? $clog2(GUIDE_SLOTS) : 1;
   localparam int CNT_W = $clog2(RECORD_CAP + 1);
   localparam logic [AW-1:0]    LAST_SLOT = AW'(GUIDE_SLOTS - 1);
   localparam logic [CNT_W-1:0] CAP       = CNT_W'(RECORD_CAP);

   // csr
   logic [LIMIT_W-1:0] limit_ff;
   logic [GBASE_W-1:0] gbase_ff;
   logic               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         gbase_ff <= GBASE_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            CSR_LIMIT: limit_ff <= pwdata[LIMIT_W-1:0];
            CSR_BASE:  gbase_ff <= pwdata[GBASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_LIMIT: prdata = {{(32-LIMIT_W){1'b0}}, limit_ff};
         CSR_BASE:  prdata = {{(32-GBASE_W){1'b0}}, gbase_ff};
         default:   prdata = '0;
      endcase
   end

   // control and datapath registers
   state_type           state_ff, state_in;
   logic [AW-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                rd_active_ff, rd_active_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]       cmp_slot_ff, cmp_slot_in;
   logic [SPACER_W-1:0] spacer_ff, spacer_in;
   logic [WIN_W-1:0]    win_ff, win_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic                pend_valid_ff, pend_valid_in;
   logic [WIN_W-1:0]    pend_win_ff, pend_win_in;
   logic [GBASE_W-1:0]  pend_gidx_ff, pend_gidx_in;
   logic [MM_W-1:0]     pend_mm_ff, pend_mm_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [WIN_W-1:0]    rsp_win_ff, rsp_win_in;
   logic [GBASE_W-1:0]  rsp_gidx_ff, rsp_gidx_in;
   logic [MM_W-1:0]     rsp_mm_ff, rsp_mm_in;
   logic [RCNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                wr_en;
   logic                rd_en;
   logic [SPACER_W-1:0] guide_q;
   logic [MM_W-1:0]     mm;
   logic                in_limit;
   logic                hit;
   logic                out_free;
   logic                hit_take;
   logic                stall;
   logic                pend_move;
   logic                accept;
   logic                pam_ok;

   gmhs_guide_ram #(
      .DEPTH (GUIDE_SLOTS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_guide_slot[AW-1:0]),
      .wr_data (req_spacer),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff),
      .rd_data (guide_q)
   );

   gmhs_base_cmp u_cmp (
      .guide      (guide_q),
      .spacer     (spacer_ff),
      .limit      (limit_ff),
      .mismatches (mm),
      .in_limit   (in_limit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_active_ff  <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_active_ff  <= rd_active_in;
         cmp_valid_ff  <= cmp_valid_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff    <= rd_cnt_in;
      cmp_slot_ff  <= cmp_slot_in;
      spacer_ff    <= spacer_in;
      win_ff       <= win_in;
      pend_win_ff  <= pend_win_in;
      pend_gidx_ff <= pend_gidx_in;
      pend_mm_ff   <= pend_mm_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_win_ff   <= rsp_win_in;
      rsp_gidx_ff  <= rsp_gidx_in;
      rsp_mm_ff    <= rsp_mm_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      pam_ok    = (req_pam[3:2] == BASE_G) && (req_pam[5:4] == BASE_G);
      wr_en     = accept && (req_opcode == OP_LOAD)
                  && ({1'b0, req_guide_slot} < 7'(GUIDE_SLOTS));

      out_free  = !rsp_valid_ff || rsp_ready;
      hit       = cmp_valid_ff && in_limit && (count_ff < CAP);
      stall     = hit && pend_valid_ff && !out_free;
      hit_take  = hit && !stall;
      pend_move = pend_valid_ff && out_free && (hit_take || (state_ff == ST_FLUSH));
      rd_en     = (state_ff == ST_SCAN) && rd_active_ff && !stall;

      state_in      = state_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_active_in  = rd_active_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_slot_in   = cmp_slot_ff;
      spacer_in     = spacer_ff;
      win_in        = win_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_win_in   = pend_win_ff;
      pend_gidx_in  = pend_gidx_ff;
      pend_mm_in    = pend_mm_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_win_in    = rsp_win_ff;
      rsp_gidx_in   = rsp_gidx_ff;
      rsp_mm_in     = rsp_mm_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;

      // read stage
      if (!stall) begin
         cmp_valid_in = rd_en;
         if (rd_en) begin
            cmp_slot_in = rd_cnt_ff;
            if (rd_cnt_ff == LAST_SLOT) begin
               rd_active_in = 1'b0;
            end else begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
         end
      end

      // held record moves out
      if (pend_move) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = 1'b0;
         rsp_win_in    = pend_win_ff;
         rsp_gidx_in   = pend_gidx_ff;
         rsp_mm_in     = pend_mm_ff;
         rsp_cnt_in    = '0;
         rsp_last_in   = (state_ff == ST_FLUSH);
         pend_valid_in = 1'b0;
      end

      if (hit_take) begin
         pend_valid_in = 1'b1;
         pend_win_in   = win_ff;
         pend_gidx_in  = gbase_ff + GBASE_W'(cmp_slot_ff);
         pend_mm_in    = mm;
         count_in      = count_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_END) begin
                  state_in = ST_SUMMARY;
               end else if ((req_opcode == OP_SCAN) && pam_ok) begin
                  state_in     = ST_SCAN;
                  rd_cnt_in    = '0;
                  rd_active_in = 1'b1;
                  spacer_in    = req_spacer;
                  win_in       = req_window_index;
               end
            end
         end
         ST_SCAN: begin
            if (cmp_valid_ff && !stall && (cmp_slot_ff == LAST_SLOT)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b1;
               rsp_win_in   = '0;
               rsp_gidx_in  = '0;
               rsp_mm_in    = '0;
               rsp_cnt_in   = RCNT_W'(count_ff);
               rsp_last_in  = 1'b1;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_hit_window   = rsp_win_ff;
   assign rsp_guide_index  = rsp_gidx_ff;
   assign rsp_mismatches   = rsp_mm_ff;
   assign rsp_record_count = rsp_cnt_ff;
   assign rsp_last         = rsp_last_ff;

   `GMHS_ASSERT(a_no_held_when_idle, clock, reset, !((state_ff == ST_IDLE) && pend_valid_ff), "held record left over after scan")
   `GMHS_ASSERT(a_count_in_cap, clock, reset, count_ff <= CAP, "record count above cap")
   `GMHS_ASSERT(a_stall_blocked, clock, reset, !stall || (rsp_valid_ff && !rsp_ready), "scan stalled with free output")
   `GMHS_ASSERT_NEXT(a_summary_clears, clock, reset, (state_ff == ST_SUMMARY) && out_free, (count_ff == '0) && rsp_valid_ff && rsp_kind_ff, "summary did not clear count")

endmodule
`default_nettype wire

>>> dv/guide_mismatch_hit_scan_top_tb.sv
`timescale 1ns / 100ps
module guide_mismatch_hit_scan_top_tb
   import gmhs_pkg::*;
();

   localparam int SLOTS = 64;
   localparam int CAP = 256;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 2 * SLOTS;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic               kind;
      logic [WIN_W-1:0]   hit_window;
      logic [GBASE_W-1:0] guide_index;
      logic [MM_W-1:0]    mismatches;
      logic [RCNT_W-1:0]  record_count;
      logic               last;
   } hit_record_type;

   class hit_scan_scoreboard;
      logic [SPACER_W-1:0] guides [SLOTS];
      int unsigned chunk_hits;
      logic [LIMIT_W-1:0] mm_limit;
      logic [GBASE_W-1:0] gbase;
      hit_record_type pending_records [$];
      int unsigned errors, requests, hits_checked, summaries, capped;

      function new();
         foreach (guides[i]) guides[i] = '0;
         chunk_hits = 0;
         mm_limit = LIMIT_RESET;
         gbase = GBASE_RESET;
         errors = 0;
         requests = 0;
         hits_checked = 0;
         summaries = 0;
         capped = 0;
      endfunction

      function void write_register(logic index, logic [31:0] value);
         if (index == CSR_LIMIT) begin
            mm_limit = value[LIMIT_W-1:0];
         end else begin
            gbase = value[GBASE_W-1:0];
         end
      endfunction

      function int unsigned base_mismatches(logic [SPACER_W-1:0] a, logic [SPACER_W-1:0] b);
         int unsigned n;
         n = 0;
         for (int i = 0; i < BASES; i++) begin
            if (a[2*i +: 2] != b[2*i +: 2]) n++;
         end
         return n;
      endfunction

      // expected records of one accepted request; the final hit of a scan carries last
      function void note_request(logic [1:0] op, logic [5:0] slot, logic [SPACER_W-1:0] spacer,
                                 logic [7:0] pam, logic [WIN_W-1:0] win);
         hit_record_type held;
         bit have;
         int unsigned mm;
         requests++;
         have = 0;
         case (op)
            OP_LOAD: guides[slot] = spacer;
            OP_END: begin
               pending_records.push_back('{kind: 1'b1, hit_window: '0, guide_index: '0,
                                          mismatches: '0, record_count: RCNT_W'(chunk_hits),
                                          last: 1'b1});
               chunk_hits = 0;
            end
            OP_SCAN: begin
               if (pam[3:2] == BASE_G && pam[5:4] == BASE_G) begin
                  for (int s = 0; s < SLOTS; s++) begin
                     mm = base_mismatches(guides[s], spacer);
                     if (mm <= mm_limit) begin
                        if (chunk_hits >= CAP) break;
                        if (have) pending_records.push_back(held);
                        held = '{kind: 1'b0, hit_window: win, guide_index: GBASE_W'(gbase + s),
                                 mismatches: MM_W'(mm), record_count: '0, last: 1'b0};
                        have = 1;
                        chunk_hits++;
                     end
                  end
                  if (have) begin
                     held.last = 1'b1;
                     pending_records.push_back(held);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t  %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_record(hit_record_type got);
         hit_record_type want;
         if (pending_records.size() == 0) begin
            errors++;
            $display("%0t  unexpected record: kind %0h window %0h guide %0h count %0h",
                     $time, got.kind, got.hit_window, got.guide_index, got.record_count);
            return;
         end
         want = pending_records.pop_front();
         if (want.kind) begin
            summaries++;
            if (want.record_count == CAP) capped++;
         end else begin
            hits_checked++;
         end
         check_field("kind", want.kind, got.kind);
         check_field("hit_window", want.hit_window, got.hit_window);
         check_field("guide_index", want.guide_index, got.guide_index);
         check_field("mismatches", want.mismatches, got.mismatches);
         check_field("record_count", want.record_count, got.record_count);
         check_field("last", want.last, got.last);
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_opcode = OP_LOAD;
   logic [5:0]          req_guide_slot = '0;
   logic [SPACER_W-1:0] req_spacer = '0;
   logic [7:0]          req_pam = '0;
   logic [WIN_W-1:0]    req_window_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_kind;
   logic [WIN_W-1:0]    rsp_hit_window;
   logic [GBASE_W-1:0]  rsp_guide_index;
   logic [MM_W-1:0]     rsp_mismatches;
   logic [RCNT_W-1:0]   rsp_record_count;
   logic                rsp_last;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [2:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   bit steady = 1'b0;
   logic [SPACER_W-1:0] families [4];
   hit_scan_scoreboard board = new();

   guide_mismatch_hit_scan_top #(
      .GUIDE_SLOTS(SLOTS),
      .RECORD_CAP(CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_guide_slot(req_guide_slot),
      .req_spacer(req_spacer),
      .req_pam(req_pam),
      .req_window_index(req_window_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_hit_window(rsp_hit_window),
      .rsp_guide_index(rsp_guide_index),
      .rsp_mismatches(rsp_mismatches),
      .rsp_record_count(rsp_record_count),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [SPACER_W-1:0] random_spacer();
      return SPACER_W'({$urandom(), $urandom()});
   endfunction

   // change count distinct bases of seq to a different code
   function automatic logic [SPACER_W-1:0] mutate_bases(logic [SPACER_W-1:0] seq,
                                                        int unsigned count);
      logic [BASES-1:0] touched;
      int unsigned pos;
      touched = '0;
      if (count > BASES) count = BASES;
      for (int i = 0; i < count; i++) begin
         do pos = $urandom_range(BASES - 1); while (touched[pos]);
         touched[pos] = 1'b1;
         seq[2*pos +: 2] = seq[2*pos +: 2] ^ 2'($urandom_range(1, 3));
      end
      return seq;
   endfunction

   task automatic send_item(logic [1:0] op, logic [5:0] slot, logic [SPACER_W-1:0] spacer,
                            logic [7:0] pam, logic [WIN_W-1:0] win);
      while (!steady && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_guide_slot <= slot;
      req_spacer <= spacer;
      req_pam <= pam;
      req_window_index <= win;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, slot, spacer, pam, win);
      @(negedge clock);
   endtask

   task automatic csr_write(logic index, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.write_register(index, value);
      @(negedge clock);
   endtask

   // registers change only once the block has drained
   task automatic set_phase(logic [LIMIT_W-1:0] limit, logic [GBASE_W-1:0] base);
      req_valid <= 1'b0;
      while (board.pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write(CSR_LIMIT, 32'(limit));
      csr_write(CSR_BASE, 32'(base));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic random_items(int unsigned count);
      logic [5:0] slot;
      logic [SPACER_W-1:0] spacer;
      logic [7:0] pam;
      logic [WIN_W-1:0] win;
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(99);
         slot = 6'($urandom());
         spacer = random_spacer();
         pam = 8'($urandom());
         win = WIN_W'($urandom());
         if (pick < 12) begin
            if ($urandom_range(4) != 0)
               spacer = mutate_bases(families[$urandom_range(3)], $urandom_range(6));
            send_item(OP_LOAD, slot, spacer, pam, win);
         end else if (pick < 70) begin
            if ($urandom_range(9) != 0)
               spacer = mutate_bases(board.guides[$urandom_range(SLOTS - 1)],
                                     $urandom_range(0, board.mm_limit + 3));
            pam[5:2] = {BASE_G, BASE_G};
            send_item(OP_SCAN, slot, spacer, pam, win);
         end else if (pick < 78) begin
            while (pam[3:2] == BASE_G && pam[5:4] == BASE_G) pam = 8'($urandom());
            send_item(OP_SCAN, slot, spacer, pam, win);
         end else if (pick < 92) begin
            send_item(OP_END, slot, spacer, pam, win);
         end else begin
            send_item(OP_UNUSED, slot, spacer, pam, win);
         end
      end
   endtask

   // result side: random backpressure unless steady, transfer checked at the rising edge
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= steady || ($urandom_range(99) >= 10);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_record('{kind: rsp_kind, hit_window: rsp_hit_window,
                                 guide_index: rsp_guide_index, mismatches: rsp_mismatches,
                                 record_count: rsp_record_count, last: rsp_last});
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t  watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [SPACER_W-1:0] fill;
      foreach (families[i]) families[i] = random_spacer();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_phase(LIMIT_RESET, GBASE_RESET);
      // every slot written before the first scan
      for (int s = 0; s < SLOTS; s++) begin
         if (s == 0)
            fill = '0;
         else if (s == SLOTS - 1)
            fill = '1;
         else
            fill = mutate_bases(families[s % 4], $urandom_range(5));
         send_item(OP_LOAD, 6'(s), fill, 8'($urandom()), WIN_W'($urandom()));
      end

      send_item(OP_SCAN, 6'd0, board.guides[5], 8'h28, 16'h0000);
      send_item(OP_SCAN, 6'd63, '1, 8'hEB, 16'hFFFF);
      send_item(OP_SCAN, 6'd0, '0, 8'h2A, 16'h0001);
      send_item(OP_SCAN, 6'd9, mutate_bases(board.guides[10], 3), 8'h29, 16'h1234);
      send_item(OP_SCAN, 6'd9, mutate_bases(board.guides[10], 4), 8'h69, 16'h1235);
      // pam gate failures
      send_item(OP_SCAN, 6'd0, board.guides[5], 8'h24, 16'h2000);
      send_item(OP_SCAN, 6'd0, board.guides[5], 8'h38, 16'h2001);
      send_item(OP_SCAN, 6'd0, board.guides[5], 8'h00, 16'h2002);
      send_item(OP_UNUSED, 6'd63, board.guides[5], 8'hEB, 16'hFFFF);
      send_item(OP_END, 6'd0, '0, 8'h00, 16'h0000);
      send_item(OP_END, 6'd63, '1, 8'hFF, 16'hFFFF);
      send_item(OP_LOAD, 6'd7, random_spacer(), 8'hFF, 16'hFFFF);
      send_item(OP_SCAN, 6'd7, board.guides[7], 8'hEA, 16'h8000);
      send_item(OP_SCAN, 6'd7, random_spacer(), 8'hE8, 16'h7FFF);
      send_item(OP_END, 6'd0, '0, 8'h00, 16'h0000);

      set_phase(5'd0, 8'd255);
      random_items(60);

      // every guide hits, so the chunk cap is reached
      set_phase(5'd20, 8'd200);
      repeat (5) send_item(OP_SCAN, 6'($urandom()), random_spacer(), 8'h28, WIN_W'($urandom()));
      send_item(OP_END, 6'($urandom()), random_spacer(), 8'($urandom()), WIN_W'($urandom()));
      random_items(40);

      steady = 1'b1;
      set_phase(LIMIT_W'($urandom_range(1, 8)), GBASE_W'($urandom()));
      random_items(110);

      steady = 1'b0;
      set_phase(LIMIT_W'($urandom_range(20)), GBASE_W'($urandom()));
      random_items(120);

      req_valid <= 1'b0;
      while (board.pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d requests: %0d hit records and %0d chunk summaries checked",
               board.requests, board.hits_checked, board.summaries);
      $display("%0d summaries at the record cap, mismatch limits 0 to 20, guide base wrap",
               board.capped);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
